/* rtl/core/pcbf_pkg.sv */
// Shared types, codes and the axis bound test for the point crop box filter.
// No dependencies; every other file refers to this package by scoped names.
package pcbf_pkg;

    // Field widths fixed by the item and result formats
    localparam int COORD_BITS    = 24;
    localparam int EXTENT_BITS   = 23;
    localparam int COUNT_BITS    = 24;
    localparam int SLOT_BITS     = 3;
    localparam int BOXCNT_BITS   = 4;
    localparam int PAD_BITS      = 20;
    localparam int FLOOR_BITS    = COORD_BITS + 1;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 24;
    // Difference of doubled coordinates, in half-millimetre units
    localparam int DIFF_BITS     = COORD_BITS + 3;

    // Item commands
    localparam logic [1:0] CMD_LOAD_BOX = 2'd0;
    localparam logic [1:0] CMD_START    = 2'd1;
    localparam logic [1:0] CMD_POINT    = 2'd2;
    localparam logic [1:0] CMD_END      = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_REMOVE_INSIDE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT_OFFSET = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_PADDING   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_COUNT     = 2'd3;

    // Result kinds
    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    typedef struct packed {
        logic [1:0]                   command;
        logic [SLOT_BITS-1:0]         box_slot;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic [EXTENT_BITS-1:0]       extent_x;
        logic [EXTENT_BITS-1:0]       extent_y;
        logic [EXTENT_BITS-1:0]       extent_z;
        logic                         finite;
    } item_t;

    typedef struct packed {
        logic                  kind;
        logic                  keep;
        logic                  in_any_box;
        logic [SLOT_BITS-1:0]  report_box;
        logic [COUNT_BITS-1:0] hit_count;
        logic                  last;
    } result_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_box;
        logic start_cloud;
        logic capture_point;
        logic eval_point;
        logic emit_verdict;
        logic report_clear;
        logic emit_report;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic no_active_box;
        logic report_last;
        logic out_free;
    } dp_status_t;

    // Test one axis: point within centre +/- (half size + padding), faces inclusive.
    // The full size in mm equals the half size in half-millimetre units.
    function automatic logic axis_in(
        input logic signed [COORD_BITS-1:0] p,
        input logic signed [COORD_BITS-1:0] c,
        input logic [EXTENT_BITS-1:0]       h,
        input logic [PAD_BITS-1:0]          pad
    );
        logic signed [DIFF_BITS-1:0] d;
        logic signed [DIFF_BITS-1:0] w;
        d = (DIFF_BITS'(p) - DIFF_BITS'(c)) <<< 1;
        w = $signed({{(DIFF_BITS-EXTENT_BITS){1'b0}}, h})
          + $signed({{(DIFF_BITS-PAD_BITS-1){1'b0}}, pad, 1'b0});
        return (d >= -w) && (d <= w);
    endfunction

endpackage

/* rtl/core/pcbf_ctrl.sv */
// Sequencing state machine for the point crop box filter.
// Depends on pcbf_pkg for command codes and the command/status structs.
module pcbf_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  logic [1:0]             item_command,
    input  pcbf_pkg::dp_status_t   status,
    output pcbf_pkg::dp_cmd_t      cmd
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_EVAL    = 2'd1;
    localparam logic [1:0] S_VERDICT = 2'd2;
    localparam logic [1:0] S_REPORT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;

    // Decode state and request into datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (item_command)
                        pcbf_pkg::CMD_LOAD_BOX: cmd.load_box = 1'b1;
                        pcbf_pkg::CMD_START:    cmd.start_cloud = 1'b1;
                        pcbf_pkg::CMD_POINT:
                        begin
                            cmd.capture_point = 1'b1;
                            state_next        = S_EVAL;
                        end
                        pcbf_pkg::CMD_END:
                        begin
                            if (!status.no_active_box)
                            begin
                                cmd.report_clear = 1'b1;
                                state_next       = S_REPORT;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_EVAL:
            begin
                cmd.eval_point = 1'b1;
                state_next     = S_VERDICT;
            end
            S_VERDICT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_verdict = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_REPORT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_report = 1'b1;
                    if (status.report_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/pcbf_datapath.sv */
// Box tables, parallel box comparators, hit counters, configuration and result register.
// Depends on pcbf_pkg for payload types, codes and the axis test.
module pcbf_datapath #(
    parameter int MAX_BOXES = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  pcbf_pkg::item_t                        item,
    input  pcbf_pkg::dp_cmd_t                      cmd,
    output pcbf_pkg::dp_status_t                   status,
    input  logic                                   cfg_valid,
    input  logic [pcbf_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [pcbf_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    output logic                                   result_valid,
    input  logic                                   result_ready,
    output pcbf_pkg::result_t                      result
);

    localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam logic [pcbf_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

    // Configuration registers
    logic                                 remove_inside_reg;
    logic signed [pcbf_pkg::COORD_BITS-1:0] height_offset_reg;
    logic [pcbf_pkg::PAD_BITS-1:0]        box_padding_reg;
    logic [pcbf_pkg::BOXCNT_BITS-1:0]     box_count_reg;

    // Box tables, no reset
    logic signed [pcbf_pkg::COORD_BITS-1:0] center_x_reg [MAX_BOXES];
    logic signed [pcbf_pkg::COORD_BITS-1:0] center_y_reg [MAX_BOXES];
    logic signed [pcbf_pkg::COORD_BITS-1:0] center_z_reg [MAX_BOXES];
    logic [pcbf_pkg::EXTENT_BITS-1:0]       half_x_reg   [MAX_BOXES];
    logic [pcbf_pkg::EXTENT_BITS-1:0]       half_y_reg   [MAX_BOXES];
    logic [pcbf_pkg::EXTENT_BITS-1:0]       half_z_reg   [MAX_BOXES];

    logic [pcbf_pkg::COUNT_BITS-1:0]        hit_count_reg [MAX_BOXES];
    logic signed [pcbf_pkg::FLOOR_BITS-1:0] floor_reg;

    // Captured point and evaluation stage
    logic signed [pcbf_pkg::COORD_BITS-1:0] pt_x_reg;
    logic signed [pcbf_pkg::COORD_BITS-1:0] pt_y_reg;
    logic signed [pcbf_pkg::COORD_BITS-1:0] pt_z_reg;
    logic                                   pt_finite_reg;
    logic [MAX_BOXES-1:0]                   hit_reg;
    logic [MAX_BOXES-1:0]                   hit_next;
    logic                                   drop_reg;
    logic                                   drop_next;

    logic [IDX_W-1:0]                       rep_idx_reg;
    logic                                   result_valid_reg;
    pcbf_pkg::result_t                      result_reg;

    logic [CNT_W-1:0]                       n_active;
    logic [IDX_W-1:0]                       load_idx;
    logic                                   load_in_range;
    logic                                   in_any;
    logic                                   out_free;

    // Clamp the active box count to the table depth
    assign n_active = (int'(box_count_reg) > MAX_BOXES) ? CNT_W'(MAX_BOXES)
                                                        : CNT_W'(box_count_reg);

    assign load_idx      = IDX_W'(item.box_slot);
    assign load_in_range = int'(item.box_slot) < MAX_BOXES;
    assign out_free      = !result_valid_reg || result_ready;
    assign in_any        = !drop_reg && (|hit_reg);

    assign status.no_active_box = (n_active == '0);
    assign status.report_last   = ((CNT_W'(rep_idx_reg) + CNT_W'(1)) == n_active);
    assign status.out_free      = out_free;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remove_inside_reg <= 1'b0;
            height_offset_reg <= '0;
            box_padding_reg   <= '0;
            box_count_reg     <= pcbf_pkg::BOXCNT_BITS'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pcbf_pkg::CFG_REMOVE_INSIDE: remove_inside_reg <= cfg_data[0];
                pcbf_pkg::CFG_HEIGHT_OFFSET:
                    height_offset_reg <= $signed(cfg_data[pcbf_pkg::COORD_BITS-1:0]);
                pcbf_pkg::CFG_BOX_PADDING:
                    box_padding_reg <= cfg_data[pcbf_pkg::PAD_BITS-1:0];
                pcbf_pkg::CFG_BOX_COUNT:
                    box_count_reg <= cfg_data[pcbf_pkg::BOXCNT_BITS-1:0];
                default: box_count_reg <= box_count_reg;
            endcase
        end
    end

    // Store a box on a load request
    always_ff @(posedge clk)
    begin
        if (cmd.load_box && load_in_range)
        begin
            center_x_reg[load_idx] <= item.pos_x;
            center_y_reg[load_idx] <= item.pos_y;
            center_z_reg[load_idx] <= item.pos_z;
            half_x_reg[load_idx]   <= item.extent_x;
            half_y_reg[load_idx]   <= item.extent_y;
            half_z_reg[load_idx]   <= item.extent_z;
        end
    end

    // Hold the point for evaluation
    always_ff @(posedge clk)
    begin
        if (cmd.capture_point)
        begin
            pt_x_reg      <= item.pos_x;
            pt_y_reg      <= item.pos_y;
            pt_z_reg      <= item.pos_z;
            pt_finite_reg <= item.finite;
        end
    end

    // Test the point against every active box in parallel
    always_comb
    begin
        for (int i = 0; i < MAX_BOXES; i++)
        begin
            hit_next[i] = (i < int'(n_active))
                && pcbf_pkg::axis_in(pt_x_reg, center_x_reg[i], half_x_reg[i], box_padding_reg)
                && pcbf_pkg::axis_in(pt_y_reg, center_y_reg[i], half_y_reg[i], box_padding_reg)
                && pcbf_pkg::axis_in(pt_z_reg, center_z_reg[i], half_z_reg[i], box_padding_reg);
        end
        drop_next = !pt_finite_reg
                 || ($signed({pt_z_reg[pcbf_pkg::COORD_BITS-1], pt_z_reg}) < floor_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval_point)
        begin
            hit_reg  <= hit_next;
            drop_reg <= drop_next;
        end
    end

    // Floor height, set on start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= '0;
        end
        else if (cmd.start_cloud)
        begin
            floor_reg <= pcbf_pkg::FLOOR_BITS'(item.pos_z)
                       + pcbf_pkg::FLOOR_BITS'(height_offset_reg);
        end
    end

    // Hit counters: clear on start, saturate on count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_BOXES; i++)
            begin
                hit_count_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < MAX_BOXES; i++)
            begin
                if (cmd.start_cloud)
                begin
                    hit_count_reg[i] <= '0;
                end
                else if (cmd.emit_verdict && !drop_reg && hit_reg[i]
                         && (hit_count_reg[i] != COUNT_MAX))
                begin
                    hit_count_reg[i] <= hit_count_reg[i] + pcbf_pkg::COUNT_BITS'(1);
                end
            end
        end
    end

    // Report index: restart on end request, advance per report
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_idx_reg <= '0;
        end
        else if (cmd.report_clear)
        begin
            rep_idx_reg <= '0;
        end
        else if (cmd.emit_report)
        begin
            rep_idx_reg <= rep_idx_reg + IDX_W'(1);
        end
    end

    // Result register: load on emit, drop the valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.emit_verdict || cmd.emit_report)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_verdict)
        begin
            result_reg.kind       <= pcbf_pkg::KIND_VERDICT;
            result_reg.keep       <= remove_inside_reg ? (!drop_reg && !in_any) : in_any;
            result_reg.in_any_box <= in_any;
            result_reg.report_box <= '0;
            result_reg.hit_count  <= '0;
            result_reg.last       <= 1'b1;
        end
        else if (cmd.emit_report)
        begin
            result_reg.kind       <= pcbf_pkg::KIND_REPORT;
            result_reg.keep       <= 1'b0;
            result_reg.in_any_box <= 1'b0;
            result_reg.report_box <= pcbf_pkg::SLOT_BITS'(rep_idx_reg);
            result_reg.hit_count  <= hit_count_reg[rep_idx_reg];
            result_reg.last       <= status.report_last;
        end
    end

endmodule

/* rtl/core/point_crop_box_filter.sv */
// Point crop box filter top level: controller plus datapath.
// A point is captured, compared against the boxes, then its verdict is registered.
// No new item is taken until a point's verdict is emitted; load and start keep the block idle.
// An end request gives one report per active box, one per cycle unless the receiver stalls.
// A verdict or report waits in place while the result register is held by a stalled receiver.
// Reset: asynchronous active low; clears control, configuration, floor and hit counters.
// Depends on pcbf_pkg, pcbf_ctrl and pcbf_datapath.
module point_crop_box_filter #(
    parameter int MAX_BOXES = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  pcbf_pkg::item_t                    item,
    output logic                               result_valid,
    input  logic                               result_ready,
    output pcbf_pkg::result_t                  result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pcbf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [pcbf_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    pcbf_pkg::dp_cmd_t    cmd;
    pcbf_pkg::dp_status_t status;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    pcbf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item_command (item.command),
        .status       (status),
        .cmd          (cmd)
    );

    pcbf_datapath #(
        .MAX_BOXES (MAX_BOXES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
